>>> hw/rtl/sit_pkg.sv
// ----------------------------------------------------------------------------
// sit_pkg
// Shared types and constants for the sorted insert table: field widths,
// operation and status codes, and the structs that run along the cell row.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned ID_W     = 16;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned COUNT_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_LOCATE = 3'd4
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    // Command broadcast to every cell in the row.
    typedef struct packed {
        logic                      capture;
        logic                      ins;
        logic                      del;
        logic signed [VALUE_W-1:0] cmp_value;
        logic [ID_W-1:0]           cmp_id;
        logic signed [VALUE_W-1:0] ins_value;
        logic [ID_W-1:0]           ins_id;
    } t_cell_cmd;

    // What a cell hands to its right-hand neighbor.
    typedef struct packed {
        logic                      lt;
        logic                      seen;
        logic signed [VALUE_W-1:0] value;
        logic [ID_W-1:0]           id;
    } t_cell_link;

    // Per-cell result flags gathered by the top level.
    typedef struct packed {
        logic ins_here;
        logic id_first;
        logic val_first;
    } t_cell_flags;

endpackage

>>> hw/rtl/sit_cell.sv
// ----------------------------------------------------------------------------
// sit_cell
// One slot of the sorted row. Holds a value and its identifier, captures the
// compare flags of an operation and shifts left or right on insert or delete.
// ----------------------------------------------------------------------------
module sit_cell
    import sit_pkg::*;
(
    input  logic                      i_clk,
    input  t_cell_cmd                 i_cmd,
    input  logic                      i_occ,
    input  t_cell_link                i_left,
    input  logic signed [VALUE_W-1:0] i_right_value,
    input  logic [ID_W-1:0]           i_right_id,
    output t_cell_link                o_link,
    output t_cell_flags               o_flags
);

    logic signed [VALUE_W-1:0] r_value;
    logic [ID_W-1:0]           r_id;
    logic                      r_lt;
    logic                      r_eq;
    logic                      r_idm;
    logic                      seen;

    assign seen = r_idm | i_left.seen;

    assign o_link.lt    = r_lt;
    assign o_link.seen  = seen;
    assign o_link.value = r_value;
    assign o_link.id    = r_id;

    // The row is sorted, so the first equal value sits just after the last
    // smaller one, and the insert slot is the first cell that is not smaller.
    assign o_flags.ins_here  = ~r_lt & i_left.lt;
    assign o_flags.val_first = r_eq & i_left.lt;
    assign o_flags.id_first  = r_idm & ~i_left.seen;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lt  <= i_occ & (r_value < i_cmd.cmp_value);
            r_eq  <= i_occ & (r_value == i_cmd.cmp_value);
            r_idm <= i_occ & (r_id == i_cmd.cmp_id);
        end
        if (i_cmd.ins) begin
            if (o_flags.ins_here) begin
                r_value <= i_cmd.ins_value;
                r_id    <= i_cmd.ins_id;
            end else if (!r_lt) begin
                r_value <= i_left.value;
                r_id    <= i_left.id;
            end
        end else if (i_cmd.del && seen) begin
            r_value <= i_right_value;
            r_id    <= i_right_id;
        end
    end

endmodule

>>> hw/rtl/sorted_insert_table_core.sv
// ----------------------------------------------------------------------------
// sorted_insert_table_core
// Sorted table of signed values with running identifiers, built as a row of
// compare-and-shift cells.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one operation per beat (opcode, item_value,
// item_id); the output channel returns exactly one result beat per operation
// (status, found_id, position, entry_count), in order.
// A beat is accepted at the edge where its valid is high and its stall low.
// At the accepting edge every cell compares its entry against the operand
// and registers the flags. At the commit edge, once the output register is
// free, the cells shift for an insert or delete and the result is loaded
// into the output register. The input stalls while an operation waits to
// commit, until its compare-then-shift pass through the cell row is done.
// A new operation may be accepted while the previous result still waits in
// the output register. If the receiver stalls, the pending operation holds
// in its commit cycle with its flags intact until the output register frees.
// Reset empties the table and sets the next identifier to one; the entries
// themselves are not cleared, since only slots below the count are read.
// The input channel stalls while reset is held.
// ----------------------------------------------------------------------------
module sorted_insert_table_core
    import sit_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic signed [VALUE_W-1:0] i_item_value,
    input  logic [ID_W-1:0]           i_item_id,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [STATUS_W-1:0]       o_status,
    output logic [ID_W-1:0]           o_found_id,
    output logic [POS_W-1:0]          o_position,
    output logic [COUNT_W-1:0]        o_entry_count
);

    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    // Operation held between the compare cycle and the commit cycle.
    logic                      r_busy;
    logic [OP_W-1:0]           r_op;
    logic signed [VALUE_W-1:0] r_value;
    logic [ID_W-1:0]           r_item_id;
    logic [CW-1:0]             r_count;
    logic [ID_W-1:0]           r_next_id;

    // Output register.
    logic                      r_out_valid;
    logic [STATUS_W-1:0]       r_status;
    logic [ID_W-1:0]           r_found_id;
    logic [POS_W-1:0]          r_position;
    logic [COUNT_W-1:0]        r_entry_count;

    logic [CW-1:0]             n_count;
    logic [ID_W-1:0]           n_next_id;
    t_status                   n_status;
    logic [ID_W-1:0]           n_found_id;
    logic [IW-1:0]             n_pos;

    logic                      accept;
    logic                      commit;
    logic                      full;
    logic                      do_ins;
    logic                      do_del;
    t_cell_cmd                 cmd;

    t_cell_link                link   [CAPACITY];
    t_cell_link                left   [CAPACITY];
    t_cell_flags               flags  [CAPACITY];
    logic [CAPACITY-1:0]       ins_vec;
    logic [CAPACITY-1:0]       idf_vec;
    logic [CAPACITY-1:0]       valf_vec;
    logic [IW-1:0]             pos_ins;
    logic [IW-1:0]             pos_id;
    logic [IW-1:0]             pos_val;
    logic [ID_W-1:0]           id_val;
    logic                      id_hit;
    logic                      val_hit;
    logic [IW+POS_W-1:0]       pos_ext;
    logic [CW+COUNT_W-1:0]     count_ext;

    // The input side is free whenever no operation sits in its commit cycle
    // and reset is released.
    assign o_in_stall = r_busy | ~i_rst_n;
    assign accept     = i_in_valid & ~o_in_stall;
    assign commit     = r_busy & (~r_out_valid | ~i_out_stall);
    assign full       = (r_count == CW'(CAPACITY));

    assign do_ins = commit && (r_op == OP_INSERT) && !full;
    assign do_del = commit && (r_op == OP_DELETE) && id_hit;

    assign cmd.capture   = accept;
    assign cmd.ins       = do_ins;
    assign cmd.del       = do_del;
    assign cmd.cmp_value = i_item_value;
    assign cmd.cmp_id    = i_item_id;
    assign cmd.ins_value = r_value;
    assign cmd.ins_id    = r_next_id;

    // Cell zero sees a virtual left neighbor that is smaller than anything
    // and holds no identifier match; the last cell refills from itself.
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic occ;
            assign occ = (CW'(gi) < r_count);

            if (gi == 0) begin : g_head
                assign left[gi].lt    = 1'b1;
                assign left[gi].seen  = 1'b0;
                assign left[gi].value = link[gi].value;
                assign left[gi].id    = link[gi].id;
            end else begin : g_body
                assign left[gi] = link[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_tail
                sit_cell u_cell (
                    .i_clk         (i_clk),
                    .i_cmd         (cmd),
                    .i_occ         (occ),
                    .i_left        (left[gi]),
                    .i_right_value (link[gi].value),
                    .i_right_id    (link[gi].id),
                    .o_link        (link[gi]),
                    .o_flags       (flags[gi])
                );
            end else begin : g_inner
                sit_cell u_cell (
                    .i_clk         (i_clk),
                    .i_cmd         (cmd),
                    .i_occ         (occ),
                    .i_left        (left[gi]),
                    .i_right_value (link[gi+1].value),
                    .i_right_id    (link[gi+1].id),
                    .o_link        (link[gi]),
                    .o_flags       (flags[gi])
                );
            end

            assign ins_vec[gi]  = flags[gi].ins_here;
            assign idf_vec[gi]  = flags[gi].id_first;
            assign valf_vec[gi] = flags[gi].val_first;
        end
    endgenerate

    // Each first-hit vector is one-hot or empty, so an OR tree encodes it.
    always_comb begin
        pos_ins = '0;
        pos_id  = '0;
        pos_val = '0;
        id_val  = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (ins_vec[i])  pos_ins = pos_ins | IW'(i);
            if (idf_vec[i])  pos_id  = pos_id  | IW'(i);
            if (valf_vec[i]) begin
                pos_val = pos_val | IW'(i);
                id_val  = id_val  | link[i].id;
            end
        end
    end

    assign id_hit  = |idf_vec;
    assign val_hit = |valf_vec;

    always_comb begin
        n_count    = r_count;
        n_next_id  = r_next_id;
        n_status   = ST_OK;
        n_found_id = '0;
        n_pos      = '0;
        case (r_op)
            OP_CLEAR: begin
                n_count = '0;
            end
            OP_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count    = r_count + CW'(1);
                    n_next_id  = r_next_id + ID_W'(1);
                    n_found_id = r_next_id;
                    n_pos      = pos_ins;
                end
            end
            OP_DELETE: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else if (!id_hit) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_count    = r_count - CW'(1);
                    n_found_id = r_item_id;
                    n_pos      = pos_id;
                end
            end
            OP_SEARCH: begin
                if (val_hit) begin
                    n_found_id = id_val;
                    n_pos      = pos_val;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            OP_LOCATE: begin
                if (id_hit) begin
                    n_found_id = r_item_id;
                    n_pos      = pos_id;
                end else begin
                    n_status = ST_NOT_FOUND;
                end
            end
            default: begin
            end
        endcase
    end

    // Only the low bits of position and count reach the ports.
    assign pos_ext   = {{POS_W{1'b0}}, n_pos};
    assign count_ext = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_count     <= '0;
            r_next_id   <= ID_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_busy <= 1'b1;
            end else if (commit) begin
                r_busy <= 1'b0;
            end
            if (commit) begin
                r_count     <= n_count;
                r_next_id   <= n_next_id;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= i_opcode;
            r_value   <= i_item_value;
            r_item_id <= i_item_id;
        end
        if (commit) begin
            r_status      <= n_status;
            r_found_id    <= n_found_id;
            r_position    <= pos_ext[POS_W-1:0];
            r_entry_count <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_id    = r_found_id;
    assign o_position    = r_position;
    assign o_entry_count = r_entry_count;

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A non-full insert finds exactly one slot in the row.
    a_ins_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_op == OP_INSERT && !full) |-> $onehot(ins_vec))
        else $error("insert slot is not unique");

    // At most one cell claims the first identifier match.
    a_id_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> $onehot0(idf_vec))
        else $error("more than one first identifier match");

    // A successful insert grows the count by one and uses one identifier.
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + CW'(1))
                   && (r_next_id == $past(r_next_id) + ID_W'(1)))
        else $error("insert did not update count and identifier");

endmodule

>>> tb/sorted_insert_table_checker.sv
// ----------------------------------------------------------------------------
// sorted_insert_table_checker
// Watches both channels of the sorted insert table. It keeps its own copy of
// the table, works out the result of every accepted operation beat, and
// compares each result beat field by field against the oldest outstanding one.
// ----------------------------------------------------------------------------
module sorted_insert_table_checker
    import sit_pkg::*;
#(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_in_stall,
    input  logic [OP_W-1:0]           i_opcode,
    input  logic signed [VALUE_W-1:0] i_item_value,
    input  logic [ID_W-1:0]           i_item_id,
    input  logic                      i_out_valid,
    input  logic                      i_out_stall,
    input  logic [STATUS_W-1:0]       i_status,
    input  logic [ID_W-1:0]           i_found_id,
    input  logic [POS_W-1:0]          i_position,
    input  logic [COUNT_W-1:0]        i_entry_count,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_status             status;
        logic [ID_W-1:0]     found_id;
        logic [POS_W-1:0]    position;
        logic [COUNT_W-1:0]  entry_count;
    } t_table_result;

    logic signed [VALUE_W-1:0] table_values [CAPACITY];
    logic [ID_W-1:0]           table_ids    [CAPACITY];
    int                        held_count;
    logic [ID_W-1:0]           next_tag;

    t_table_result awaited_results[$];
    int            fail_total = 0;

    // Lowest position holding this identifier, or -1.
    function automatic int find_tag(input logic [ID_W-1:0] tag);
        for (int k = 0; k < held_count; k++) begin
            if (table_ids[k] == tag) return k;
        end
        return -1;
    endfunction

    function automatic t_table_result apply_table_op(input logic [OP_W-1:0] op,
                                                     input logic signed [VALUE_W-1:0] val,
                                                     input logic [ID_W-1:0] tag);
        t_table_result res;
        int            slot;
        res = '{status: ST_OK, found_id: '0, position: '0, entry_count: '0};
        case (op)
            OP_CLEAR: begin
                held_count = 0;
            end
            OP_INSERT: begin
                if (held_count >= CAPACITY) begin
                    res.status = ST_FULL;
                end else begin
                    slot = 0;
                    while (slot < held_count && table_values[slot] < val) slot++;
                    for (int k = held_count; k > slot; k--) begin
                        table_values[k] = table_values[k-1];
                        table_ids[k]    = table_ids[k-1];
                    end
                    table_values[slot] = val;
                    table_ids[slot]    = next_tag;
                    res.found_id       = next_tag;
                    res.position       = POS_W'(slot);
                    next_tag           = next_tag + 1'b1;
                    held_count++;
                end
            end
            OP_DELETE: begin
                if (held_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    slot = find_tag(tag);
                    if (slot < 0) begin
                        res.status = ST_NOT_FOUND;
                    end else begin
                        res.found_id = tag;
                        res.position = POS_W'(slot);
                        for (int k = slot; k + 1 < held_count; k++) begin
                            table_values[k] = table_values[k+1];
                            table_ids[k]    = table_ids[k+1];
                        end
                        held_count--;
                    end
                end
            end
            OP_SEARCH: begin
                res.status = ST_NOT_FOUND;
                for (int k = 0; k < held_count; k++) begin
                    if (table_values[k] == val) begin
                        res.status   = ST_OK;
                        res.found_id = table_ids[k];
                        res.position = POS_W'(k);
                        break;
                    end
                end
            end
            OP_LOCATE: begin
                slot = find_tag(tag);
                if (slot < 0) begin
                    res.status = ST_NOT_FOUND;
                end else begin
                    res.found_id = tag;
                    res.position = POS_W'(slot);
                end
            end
            default: begin
            end
        endcase
        res.entry_count = COUNT_W'(held_count);
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            held_count = 0;
            next_tag   = 1;
            awaited_results.delete();
        end else begin
            // Results leave in order, so the oldest outstanding one is compared
            // before this edge's operation beat, if any, is added.
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with no operation outstanding");
                    fail_total++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("status", int'(want.status), int'(i_status));
                    check_field("found_id", int'(want.found_id), int'(i_found_id));
                    check_field("position", int'(want.position), int'(i_position));
                    check_field("entry_count", int'(want.entry_count),
                                int'(i_entry_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                awaited_results.push_back(apply_table_op(i_opcode, i_item_value, i_item_id));
            end
        end
        o_pending    = awaited_results.size();
        o_fail_count = fail_total;
    end

endmodule

>>> tb/sorted_insert_table_core_tb.sv
// ----------------------------------------------------------------------------
// sorted_insert_table_core_tb
// Stimulus and verdict for the sorted insert table. A short directed run
// covers the field extremes, every operation and the empty and spare opcode
// cases; a long random phase with idle gaps on both sides follows, with
// insert bursts that fill the table. The checker beside the block does all
// the predicting and comparing.
// ----------------------------------------------------------------------------
module sorted_insert_table_core_tb;
    import sit_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_SLOTS  = 16;
    localparam int unsigned CLK_PERIOD   = 20;
    localparam int unsigned RESET_CYCLES = 7;
    localparam int unsigned MAX_IDLE     = 6;
    localparam int unsigned LONG_HOLD    = 150;
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned RANDOM_ITEMS = 1750;
    localparam int unsigned CYCLE_LIMIT  = 200_000;
    localparam int unsigned VALUE_POOL   = 32;

    // Opcodes the block treats as no operation.
    localparam logic [OP_W-1:0] OP_SPARE_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_LAST  = 3'd7;

    localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    logic [OP_W-1:0]           opcode     = '0;
    logic signed [VALUE_W-1:0] item_value = '0;
    logic [ID_W-1:0]           item_id    = '0;
    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic [STATUS_W-1:0]       status;
    logic [ID_W-1:0]           found_id;
    logic [POS_W-1:0]          position;
    logic [COUNT_W-1:0]        entry_count;

    int fail_count;
    int pending;

    // The sender asks for a long receiver hold by bumping this count.
    int long_holds_wanted = 0;
    int long_holds_served = 0;

    // What the sender knows about occupancy: the identifiers it believes are
    // held (as a multiset) and how many identifiers have been handed out.
    // This only steers the stimulus.
    logic [ID_W-1:0]           live_tags[$];
    logic signed [VALUE_W-1:0] recent_values[$];
    int unsigned               tags_issued = 0;
    int unsigned               items_sent  = 0;

    always #(CLK_PERIOD/2) clk = ~clk;

    sorted_insert_table_core #(
        .CAPACITY(TABLE_SLOTS)
    ) DUT (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_item_value (item_value),
        .i_item_id    (item_id),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_status     (status),
        .o_found_id   (found_id),
        .o_position   (position),
        .o_entry_count(entry_count)
    );

    sorted_insert_table_checker #(
        .CAPACITY(TABLE_SLOTS)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_opcode     (opcode),
        .i_item_value (item_value),
        .i_item_id    (item_id),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_status     (status),
        .i_found_id   (found_id),
        .i_position   (position),
        .i_entry_count(entry_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // ------------------------------------------------------------------
    // Result side. After every accepted result beat the receiver draws how
    // many cycles to stall before taking the next one. A requested long hold
    // overrides that and keeps the stall up long enough for the block to
    // back up into its input channel.
    // ------------------------------------------------------------------
    logic        result_taken = 1'b0;
    int unsigned stall_left   = 0;

    always @(posedge clk) begin
        result_taken <= rst_n && out_valid && !out_stall;
    end

    always @(negedge clk) begin
        if (long_holds_served != long_holds_wanted) begin
            long_holds_served = long_holds_wanted;
            stall_left        = LONG_HOLD;
        end else if (result_taken) begin
            stall_left = $urandom_range(0, MAX_IDLE);
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Operation side. One call sends one beat: it idles for a drawn number
    // of cycles, presents the beat at a falling edge and returns at the
    // rising edge that accepts it. The payload stays put while stalled.
    // ------------------------------------------------------------------
    task automatic issue(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] val,
                         input logic [ID_W-1:0] tag);
        int unsigned gap;
        int          hits[$];
        gap = $urandom_range(0, MAX_IDLE);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        item_value <= val;
        item_id    <= tag;
        do @(posedge clk); while (in_stall);
        items_sent++;

        // Keep the occupancy picture in step with what the beat did.
        case (op)
            OP_CLEAR: begin
                live_tags.delete();
            end
            OP_INSERT: begin
                recent_values.push_back(val);
                if (recent_values.size() > VALUE_POOL) void'(recent_values.pop_front());
                if (live_tags.size() < TABLE_SLOTS) begin
                    live_tags.push_back(ID_W'(tags_issued + 1));
                    tags_issued++;
                end
            end
            OP_DELETE: begin
                hits = live_tags.find_first_index(x) with (x == tag);
                if (hits.size() > 0) live_tags.delete(hits[0]);
            end
            default: begin
            end
        endcase
    endtask

    // Values lean toward a narrow band around zero so that equal values are
    // common, with the extremes and fully random words mixed in.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 4))
            0, 1: return $signed($urandom_range(0, 8)) - 4;
            2: begin
                case ($urandom_range(0, 3))
                    0: return VALUE_MIN;
                    1: return VALUE_MAX;
                    2: return -1;
                    default: return 0;
                endcase
            end
            default: return $urandom();
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_search_value();
        if (recent_values.size() > 0 && $urandom_range(0, 9) < 7)
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        return pick_value();
    endfunction

    // Mostly identifiers that are held, some recently issued ones that may
    // be gone already, and a few arbitrary ones.
    function automatic logic [ID_W-1:0] pick_tag();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (live_tags.size() > 0 && r < 7)
            return live_tags[$urandom_range(0, live_tags.size() - 1)];
        if (r < 9)
            return ID_W'(tags_issued + 1 - $urandom_range(0, 40));
        return ID_W'($urandom());
    endfunction

    // Hard stop in case the handshake hangs.
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("sorted_insert_table_core_tb: errors");
        $finish;
    end

    initial begin : stimulus
        int unsigned     random_start;
        int unsigned     r;
        bit              hold_done;
        bit              drain_done;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed ----------------
        // The counter starts at one, so the first insert gets identifier one.
        issue(OP_DELETE, 0, 16'd1);                 // delete from an empty table
        issue(OP_SEARCH, 0, 0);                     // search in an empty table
        issue(OP_LOCATE, 0, 16'hFFFF);              // locate in an empty table
        issue(OP_INSERT, VALUE_MAX, 0);
        issue(OP_INSERT, VALUE_MIN, 0);
        issue(OP_INSERT, 0, 0);
        issue(OP_INSERT, 0, 0);                     // equal value goes ahead
        issue(OP_INSERT, -1, 0);
        issue(OP_SEARCH, 0, 0);                     // first of the equal pair
        issue(OP_SEARCH, 32'sd12345, 0);            // value not present
        issue(OP_LOCATE, 0, 16'd1);                 // largest value, last slot
        issue(OP_LOCATE, 0, 16'hFFFF);              // id not present
        issue(OP_DELETE, 0, 16'd3);
        issue(OP_DELETE, 0, 16'd3);                 // already gone
        issue(OP_SEARCH, VALUE_MIN, 0);
        issue(OP_SPARE_FIRST, -1, 16'hFFFF);        // spare opcodes do nothing
        issue(OP_SPARE_LAST, 0, 0);
        issue(OP_CLEAR, -1, 16'hFFFF);
        issue(OP_INSERT, 32'sd7, 0);                // counter survives a clear
        issue(OP_DELETE, 0, live_tags[0]);
        issue(OP_SEARCH, 32'sd7, 0);

        // ---------------- random ----------------
        random_start = items_sent;
        hold_done    = 1'b0;
        drain_done   = 1'b0;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            // Once, stall the result side for a long stretch while beats keep
            // coming, so the block backs up.
            if (!hold_done && items_sent - random_start >= 600) begin
                hold_done = 1'b1;
                long_holds_wanted++;
            end
            // Once, stop sending until every outstanding result has come back.
            if (!drain_done && items_sent - random_start >= 1100) begin
                drain_done = 1'b1;
                @(negedge clk);
                in_valid <= 1'b0;
                wait (pending == 0);
            end
            r = $urandom_range(0, 99);
            if (r < 6) begin
                repeat ($urandom_range(4, 18)) issue(OP_INSERT, pick_value(), ID_W'($urandom()));
            end else if (r < 36) begin
                issue(OP_INSERT, pick_value(), ID_W'($urandom()));
            end else if (r < 52) begin
                issue(OP_DELETE, pick_value(), pick_tag());
            end else if (r < 66) begin
                issue(OP_SEARCH, pick_search_value(), ID_W'($urandom()));
            end else if (r < 80) begin
                issue(OP_LOCATE, pick_value(), pick_tag());
            end else if (r < 83) begin
                issue(OP_CLEAR, pick_value(), ID_W'($urandom()));
            end else if (r < 86) begin
                issue(OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), $urandom(),
                      ID_W'($urandom()));
            end else begin
                // Noise: any opcode, any fields.
                issue(OP_W'($urandom_range(0, (1 << OP_W) - 1)), $urandom(),
                      ID_W'($urandom()));
            end
        end

        // ---------------- wind down ----------------
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("sorted_insert_table_core_tb: clean");
        end else begin
            $display("sorted_insert_table_core_tb: errors");
        end
        $finish;
    end

endmodule
